// File: src/bfga_pkg.sv
// ----------------------------------------------------------------------------
// bfga_pkg
// Shared types and codes for the best-fit range allocator.
// ----------------------------------------------------------------------------
package bfga_pkg;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam int OFFSET_BITS = 48;
    localparam int TOTAL_BITS  = 49;

    typedef struct packed {
        logic                   cmd;
        logic [OFFSET_BITS-1:0] start;
        logic [31:0]            size;
    } t_cmd;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] position;
        logic [1:0]             status;
        logic [TOTAL_BITS-1:0]  total_free;
    } t_res;
endpackage

// File: src/bfga_front.sv
// ----------------------------------------------------------------------------
// bfga_front
// Accepts command beats into a short queue and hands them to the engine.
// ----------------------------------------------------------------------------
module bfga_front import bfga_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// File: src/bfga_engine.sv
// ----------------------------------------------------------------------------
// bfga_engine
// Scans the range table one entry a cycle, applies the command (a non-positive size
// skips both), recounts the free total in a second sweep, registers the result.
// ----------------------------------------------------------------------------
module bfga_engine import bfga_pkg::*; #(
    parameter int MAX_RANGES  = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int OB = OFFSET_BITS;
    localparam logic [OB:0] OFS_MAX = {1'b0, {OB{1'b1}}};
    localparam logic [TOTAL_BITS-1:0] TOT_MAX = {TOTAL_BITS{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_APPLY = 3'd2,
                           S_SUM = 3'd3, S_OUT = 3'd4;

    logic [OB-1:0] r_st [MAX_RANGES];
    logic [OB-1:0] r_sz [MAX_RANGES];
    logic [31:0]   r_ag [MAX_RANGES];
    logic [MAX_RANGES-1:0] r_vld;
    logic [31:0] r_age;

    logic [2:0]  r_state;
    logic [IW:0] r_idx;
    t_cmd        r_c;
    logic [OB-1:0] r_start;
    logic [OB-1:0] r_size;
    logic        r_dup;
    logic        r_lo_ok, r_hi_ok, r_slot_ok, r_best_ok;
    logic [IW-1:0] r_lo, r_hi, r_slot, r_best;
    logic [OB-1:0] r_lo_st, r_lo_sz, r_hi_st, r_hi_sz, r_b_sz, r_b_st;
    logic [31:0]   r_b_ag;
    logic [1:0]    r_status;
    logic          r_found;
    logic [OB-1:0] r_pos;
    logic [TOTAL_BITS-1:0] r_sum;
    t_res          r_res;

    // one registered read per cycle
    logic [OB-1:0] r_rd_st, r_rd_sz;
    logic [31:0]   r_rd_ag;
    logic          r_rd_v, r_rd_go;
    logic [IW-1:0] r_rd_i;

    logic [IW-1:0] w_i;
    logic          w_pos;
    logic [OB-1:0] w_req;
    assign w_i   = r_idx[IW-1:0];
    assign w_pos = (i_cmd.size != 32'd0) && !i_cmd.size[31];
    assign w_req = OB'(r_c.size);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_res   = r_res;

    // add-side merge arithmetic
    logic [OB:0]   w_lo_end, w_m_sz, w_hi_end, w_m2_sz;
    logic          w_lo_m, w_hi_m;
    logic [OB-1:0] w_m_st;
    always_comb begin
        w_lo_end = {1'b0, r_lo_st} + {1'b0, r_lo_sz};
        w_lo_m   = r_lo_ok && (w_lo_end == {1'b0, r_start});
        w_m_st   = w_lo_m ? r_lo_st : r_start;
        w_m_sz   = w_lo_m ? ({1'b0, r_lo_sz} + {1'b0, r_size}) : {1'b0, r_size};
        if (w_m_sz > OFS_MAX) w_m_sz = OFS_MAX;
        w_hi_end = {1'b0, w_m_st} + w_m_sz;
        w_hi_m   = r_hi_ok && (w_hi_end == {1'b0, r_hi_st});
        w_m2_sz  = w_m_sz + {1'b0, r_hi_sz};
        if (w_m2_sz > OFS_MAX) w_m2_sz = OFS_MAX;
    end

    logic [31:0] w_di, w_db;
    assign w_di = r_age - r_rd_ag;
    assign w_db = r_age - r_b_ag;
    logic [TOTAL_BITS:0] w_acc;
    assign w_acc = {1'b0, r_sum} + (TOTAL_BITS+1)'(r_rd_sz);

    always_ff @(posedge i_clk) begin
        r_rd_st <= r_st[w_i];
        r_rd_sz <= r_sz[w_i];
        r_rd_ag <= r_ag[w_i];
        r_rd_v  <= r_vld[w_i];
        r_rd_i  <= w_i;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_age   <= '0;
            r_rd_go <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_c       <= i_cmd;
                    r_start   <= OB'(i_cmd.start);
                    r_size    <= OB'(i_cmd.size);
                    r_idx     <= '0;
                    r_dup     <= 1'b0;
                    r_lo_ok   <= 1'b0;
                    r_hi_ok   <= 1'b0;
                    r_slot_ok <= 1'b0;
                    r_best_ok <= 1'b0;
                    r_found   <= 1'b0;
                    r_pos     <= '0;
                    r_rd_go   <= 1'b0;
                    if (!w_pos) begin
                        r_status <= (i_cmd.cmd == CMD_ADD) ? ST_IGNORED : ST_NOFIT;
                        r_state  <= S_SUM;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx != (IW+1)'(MAX_RANGES)) r_idx <= r_idx + 1'b1;
                    r_rd_go <= (r_idx != (IW+1)'(MAX_RANGES));
                    if (r_rd_go) begin
                        if (!r_rd_v) begin
                            if (!r_slot_ok) begin
                                r_slot_ok <= 1'b1;
                                r_slot    <= r_rd_i;
                            end
                        end else if (r_c.cmd == CMD_ADD) begin
                            if (r_rd_st == r_start) r_dup <= 1'b1;
                            else if (r_rd_st < r_start) begin
                                if (!r_lo_ok || r_rd_st > r_lo_st) begin
                                    r_lo_ok <= 1'b1; r_lo <= r_rd_i;
                                    r_lo_st <= r_rd_st; r_lo_sz <= r_rd_sz;
                                end
                            end else if (!r_hi_ok || r_rd_st < r_hi_st) begin
                                r_hi_ok <= 1'b1; r_hi <= r_rd_i;
                                r_hi_st <= r_rd_st; r_hi_sz <= r_rd_sz;
                            end
                        end else if (r_rd_sz >= w_req) begin
                            if (!r_best_ok || r_rd_sz < r_b_sz ||
                                (r_rd_sz == r_b_sz && w_di > w_db)) begin
                                r_best_ok <= 1'b1; r_best <= r_rd_i;
                                r_b_sz <= r_rd_sz; r_b_st <= r_rd_st;
                                r_b_ag <= r_rd_ag;
                            end
                        end
                    end else if (r_idx == (IW+1)'(MAX_RANGES)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_SUM;
                    r_idx   <= '0;
                    r_rd_go <= 1'b0;
                    if (r_c.cmd == CMD_ADD) begin
                        if (r_dup) r_status <= ST_IGNORED;
                        else if (w_lo_m) begin
                            r_status <= ST_OK;
                            r_st[r_lo] <= w_m_st;
                            r_ag[r_lo] <= r_age;
                            r_age <= r_age + 1'b1;
                            if (w_hi_m) begin
                                r_sz[r_lo] <= w_m2_sz[OB-1:0];
                                r_vld[r_hi] <= 1'b0;
                            end else r_sz[r_lo] <= w_m_sz[OB-1:0];
                        end else if (w_hi_m) begin
                            r_status <= ST_OK;
                            r_st[r_hi] <= w_m_st;
                            r_sz[r_hi] <= w_m2_sz[OB-1:0];
                            r_ag[r_hi] <= r_age;
                            r_age <= r_age + 1'b1;
                        end else if (r_slot_ok) begin
                            r_status <= ST_OK;
                            r_st[r_slot] <= r_start;
                            r_sz[r_slot] <= r_size;
                            r_ag[r_slot] <= r_age;
                            r_vld[r_slot] <= 1'b1;
                            r_age <= r_age + 1'b1;
                        end else r_status <= ST_FULL;
                    end else if (!r_best_ok) begin
                        r_status <= ST_NOFIT;
                    end else begin
                        r_status <= ST_OK;
                        r_found  <= 1'b1;
                        r_pos    <= r_b_st;
                        if (r_b_sz > w_req) begin
                            r_st[r_best] <= r_b_st + w_req;
                            r_sz[r_best] <= r_b_sz - w_req;
                            r_ag[r_best] <= r_age;
                            r_age <= r_age + 1'b1;
                        end else r_vld[r_best] <= 1'b0;
                    end
                end
                S_SUM: begin
                    // recount the total over the whole table
                    if (r_idx == '0 && !r_rd_go) begin
                        r_sum <= '0;
                    end else if (r_rd_go && r_rd_v) begin
                        r_sum <= (w_acc > {1'b0, TOT_MAX}) ? TOT_MAX
                                                           : w_acc[TOTAL_BITS-1:0];
                    end
                    if (r_idx != (IW+1)'(MAX_RANGES)) r_idx <= r_idx + 1'b1;
                    r_rd_go <= (r_idx != (IW+1)'(MAX_RANGES));
                    if (!r_rd_go && r_idx == (IW+1)'(MAX_RANGES)) begin
                        r_res.found      <= r_found;
                        r_res.position   <= r_pos;
                        r_res.status     <= r_status;
                        r_res.total_free <= r_sum;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/best_fit_gap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_gap_allocator
// Best-fit free-range table with coalescing on add.
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)                  tuser
// s_axis    in   range_start[47:0], range_size[79:48]         cmd
// m_axis    out  position[47:0], total_free[96:48]            found, status
//
// An item takes one sweep of the table for best fit or neighbors, one write,
// and a second sweep to recount the total. A non-positive size skips the
// first sweep and the write. The table read port reads one entry a cycle.
// Reset clears the valid bits at once; no clearing pass.
// A two-deep queue accepts beats while the engine works or its result waits.
// ----------------------------------------------------------------------------
module best_fit_gap_allocator import bfga_pkg::*; #(
    parameter int MAX_RANGES  = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,   // range_start, range_size
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // position, total_free, zero fill
    output logic [2:0]   m_axis_tuser    // found, status
);
    t_cmd w_in, w_q;
    t_res w_res;
    logic w_qv, w_qr;

    assign w_in.cmd   = s_axis_tuser;
    assign w_in.start = s_axis_tdata[47:0];
    assign w_in.size  = s_axis_tdata[79:48];

    bfga_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    bfga_engine #(.MAX_RANGES(MAX_RANGES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.total_free, w_res.position};
    assign m_axis_tuser = {w_res.status, w_res.found};

`ifndef SYNTH
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.found |-> w_res.status == ST_OK) else $error("found");
    a_nf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_res.found |-> w_res.position == 48'd0) else $error("pos");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_qr) else $error("busy");
`endif
endmodule
